// ===== sv/rsp_pkg.sv =====
// Shared constants, codes and small character helpers for the request stream parser.
// No dependencies; the top level and the header unit import this package.
package rsp_pkg;

  // Parse modes
  localparam logic [1:0] MODE_LINE   = 2'd0;
  localparam logic [1:0] MODE_HEADER = 2'd1;
  localparam logic [1:0] MODE_BODY   = 2'd2;

  // Header line phases
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_SPACE  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  // Byte classes
  localparam logic [2:0] CLS_SEP    = 3'd0;
  localparam logic [2:0] CLS_TYPE   = 3'd1;
  localparam logic [2:0] CLS_PATH   = 3'd2;
  localparam logic [2:0] CLS_DEVICE = 3'd3;
  localparam logic [2:0] CLS_HDR    = 3'd4;
  localparam logic [2:0] CLS_BODY   = 3'd5;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;

  localparam int unsigned KEY_LEN  = 9;
  localparam int unsigned SAVE_LEN = 4;
  localparam int unsigned GET_LEN  = 3;

  // Header line position and phase, passed between top level and header unit
  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] pos;
  } hdr_ctl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // "filesize:" by position
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h66; // f
      4'd1: r = 8'h69; // i
      4'd2: r = 8'h6c; // l
      4'd3: r = 8'h65; // e
      4'd4: r = 8'h73; // s
      4'd5: r = 8'h69; // i
      4'd6: r = 8'h7a; // z
      4'd7: r = 8'h65; // e
      4'd8: r = 8'h3a; // :
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] save_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h53; // S
      2'd1: r = 8'h41; // A
      2'd2: r = 8'h56; // V
      2'd3: r = 8'h45; // E
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h47; // G
      2'd1: r = 8'h45; // E
      2'd2: r = 8'h54; // T
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/rsp_in_if.sv =====
// Input byte channel of the request stream parser: valid/ready plus one data byte.
// No dependencies.
interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== sv/rsp_out_if.sv =====
// Result channel of the request stream parser: valid/ready plus the tagged byte and events.
// No dependencies.
interface rsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_byte;
  logic [2:0]  byte_class;
  logic        body_last;
  logic        request_ready;
  logic        request_kind;
  logic [31:0] file_size;
  logic        save_done;

  modport source (
    output valid, output echo_byte, output byte_class, output body_last,
    output request_ready, output request_kind, output file_size, output save_done,
    input ready
  );
  modport sink (
    input valid, input echo_byte, input byte_class, input body_last,
    input request_ready, input request_kind, input file_size, input save_done,
    output ready
  );
endinterface

// ===== sv/request_stream_parser.sv =====
// Top level of the request stream parser: byte channel in, tagged result channel out.
// Depends on rsp_pkg, rsp_in_if, rsp_out_if and rsp_hdr_unit.
//
// Usage
//   stream : one byte of the connection per item (valid/ready, data_byte).
//   result : one item per input byte, carrying the byte back with its class
//            (separator, type, path, device id, header, body), body_last,
//            and the events request_ready (with request_kind and file_size)
//            and save_done.
//   Latency: the result of a byte is presented the cycle after the byte is
//   accepted; one registered pass of parse logic sits in between.
//   Throughput: one byte per cycle. The single result register refills in
//   the cycle it is drained, so stream.ready stays high while the receiver
//   keeps taking results.
//   Stall: when a result is held and result.ready is low, stream.ready
//   drops; the held result and all parser state stay put until taken.
//   Reset (rst, synchronous): parser back to request line mode, size and
//   body count cleared, result register empty.
//   SIZE_BITS sets the width of the size accumulator and body counter;
//   file_size always shows its low 32 bits.
module request_stream_parser #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  rsp_in_if.sink     stream,
  rsp_out_if.source  result
);
  import rsp_pkg::*;

  // Parser state
  logic [1:0]           parse_mode,     parse_mode_next;
  logic [1:0]           token_number,   token_number_next;
  logic                 in_token,       in_token_next;
  logic                 scan_stopped,   scan_stopped_next;
  logic [2:0]           type_progress,  type_progress_next;
  logic                 type_is_save,   type_is_save_next;
  logic                 type_is_get,    type_is_get_next;
  logic                 pending_cr,     pending_cr_next;
  logic [3:0]           line_position,  line_position_next;
  logic [1:0]           header_phase,   header_phase_next;
  logic [SIZE_BITS-1:0] size_value,     size_value_next;
  logic [SIZE_BITS-1:0] body_remaining, body_remaining_next;

  // Result register
  logic        res_valid;
  logic [7:0]  res_byte;
  logic [2:0]  res_class;
  logic        res_last;
  logic        res_ready_ev;
  logic        res_kind;
  logic [31:0] res_size;
  logic        res_done;

  // Combinational result of the byte being accepted
  logic [2:0]  cls;
  logic        last, ready_ev, kind, done;
  logic [31:0] fsz;
  logic        start_req;

  logic [7:0]  c;
  logic        accept;
  logic        is_header;
  logic        line_end;
  logic        sv_ok, gt_ok;
  logic [63:0] size_wide;

  hdr_ctl_t             hdr_cur, hdr_upd;
  logic [SIZE_BITS-1:0] hdr_size;

  assign c         = stream.data_byte;
  // the result register is free, or is being emptied this cycle
  assign stream.ready = !res_valid || result.ready;
  assign accept    = stream.valid && stream.ready;
  assign is_header = (parse_mode == MODE_HEADER);
  assign line_end  = pending_cr && (c == CH_LF);
  assign sv_ok     = type_is_save && (type_progress == 3'(SAVE_LEN));
  assign gt_ok     = type_is_get  && (type_progress == 3'(GET_LEN));
  assign size_wide = 64'(size_value);

  assign hdr_cur = '{phase: header_phase, pos: line_position};

  // Header line content: a held CR first, then the new byte unless it is a CR itself
  rsp_hdr_unit #(.SIZE_BITS(SIZE_BITS)) u_hdr (
    .cur      (hdr_cur),
    .size     (size_value),
    .data     (c),
    .do_cr    (pending_cr),
    .do_byte  (c != CH_CR),
    .upd      (hdr_upd),
    .size_upd (hdr_size)
  );

  // Next state and result for one byte
  always_comb begin
    parse_mode_next     = parse_mode;
    token_number_next   = token_number;
    in_token_next       = in_token;
    scan_stopped_next   = scan_stopped;
    type_progress_next  = type_progress;
    type_is_save_next   = type_is_save;
    type_is_get_next    = type_is_get;
    pending_cr_next     = pending_cr;
    line_position_next  = line_position;
    header_phase_next   = header_phase;
    size_value_next     = size_value;
    body_remaining_next = body_remaining;

    cls       = CLS_SEP;
    last      = 1'b0;
    ready_ev  = 1'b0;
    kind      = 1'b0;
    done      = 1'b0;
    fsz       = 32'd0;
    start_req = 1'b0;

    if (parse_mode == MODE_BODY) begin
      // body bytes counted raw
      cls = CLS_BODY;
      if (body_remaining <= SIZE_BITS'(1)) begin
        last                = 1'b1;
        done                = 1'b1;
        body_remaining_next = '0;
        start_req           = 1'b1;
      end else begin
        body_remaining_next = body_remaining - SIZE_BITS'(1);
      end
    end else if (line_end) begin
      cls             = is_header ? CLS_HDR : CLS_SEP;
      pending_cr_next = 1'b0;
      if (!is_header) begin
        parse_mode_next    = MODE_HEADER;
        line_position_next = 4'd0;
        header_phase_next  = PH_PREFIX;
      end else if (line_position == 4'd0) begin
        // blank line closes the header of a SAVE or GET request
        if (sv_ok || gt_ok) begin
          ready_ev = 1'b1;
          kind     = sv_ok;
          fsz      = size_wide[31:0];
          if (sv_ok && (size_value != '0)) begin
            parse_mode_next     = MODE_BODY;
            body_remaining_next = size_value;
          end else begin
            done      = sv_ok;
            start_req = 1'b1;
          end
        end else begin
          header_phase_next = PH_PREFIX;
        end
      end else begin
        line_position_next = 4'd0;
        header_phase_next  = PH_PREFIX;
      end
    end else begin
      pending_cr_next = (c == CH_CR);
      if (is_header) begin
        cls                = CLS_HDR;
        header_phase_next  = hdr_upd.phase;
        line_position_next = hdr_upd.pos;
        size_value_next    = hdr_size;
      end else begin
        // a held CR that was not a line end stops the token scan
        if (pending_cr && !scan_stopped && (token_number != 2'd3)) begin
          scan_stopped_next = 1'b1;
        end
        if ((c != CH_CR) && !scan_stopped_next && (token_number != 2'd3)) begin
          if (is_blank(c)) begin
            if (in_token) begin
              in_token_next     = 1'b0;
              token_number_next = token_number + 2'd1;
            end
          end else if (is_ws(c)) begin
            scan_stopped_next = 1'b1;
          end else begin
            in_token_next = 1'b1;
            cls           = 3'(token_number) + CLS_TYPE;
            if (token_number == 2'd0) begin
              if ((type_progress >= 3'(SAVE_LEN)) || (c != save_char(type_progress[1:0])))
              begin
                type_is_save_next = 1'b0;
              end
              if ((type_progress >= 3'(GET_LEN)) || (c != get_char(type_progress[1:0])))
              begin
                type_is_get_next = 1'b0;
              end
              if (type_progress != 3'd7) begin
                type_progress_next = type_progress + 3'd1;
              end
            end
          end
        end
      end
    end

    if (start_req) begin
      parse_mode_next    = MODE_LINE;
      token_number_next  = 2'd0;
      in_token_next      = 1'b0;
      scan_stopped_next  = 1'b0;
      type_progress_next = 3'd0;
      type_is_save_next  = 1'b1;
      type_is_get_next   = 1'b1;
      pending_cr_next    = 1'b0;
      line_position_next = 4'd0;
      header_phase_next  = PH_PREFIX;
      size_value_next    = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode     <= MODE_LINE;
      token_number   <= 2'd0;
      in_token       <= 1'b0;
      scan_stopped   <= 1'b0;
      type_progress  <= 3'd0;
      type_is_save   <= 1'b1;
      type_is_get    <= 1'b1;
      pending_cr     <= 1'b0;
      line_position  <= 4'd0;
      header_phase   <= PH_PREFIX;
      size_value     <= '0;
      body_remaining <= '0;
    end else if (accept) begin
      parse_mode     <= parse_mode_next;
      token_number   <= token_number_next;
      in_token       <= in_token_next;
      scan_stopped   <= scan_stopped_next;
      type_progress  <= type_progress_next;
      type_is_save   <= type_is_save_next;
      type_is_get    <= type_is_get_next;
      pending_cr     <= pending_cr_next;
      line_position  <= line_position_next;
      header_phase   <= header_phase_next;
      size_value     <= size_value_next;
      body_remaining <= body_remaining_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte     <= c;
      res_class    <= cls;
      res_last     <= last;
      res_ready_ev <= ready_ev;
      res_kind     <= kind;
      res_size     <= fsz;
      res_done     <= done;
    end
  end

  assign result.valid         = res_valid;
  assign result.echo_byte     = res_byte;
  assign result.byte_class    = res_class;
  assign result.body_last     = res_last;
  assign result.request_ready = res_ready_ev;
  assign result.request_kind  = res_kind;
  assign result.file_size     = res_size;
  assign result.save_done     = res_done;

  // A held result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(stream.ready && result.valid && !result.ready))
    else $error("input taken while a result is stalled");

  // Request events only come from the LF of a blank header line
  a_ready_on_lf: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.request_ready |->
      (result.echo_byte == CH_LF) && (result.byte_class == CLS_HDR))
    else $error("request_ready on a byte that is not a header LF");

  // save_done ends a body or a zero-size SAVE
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.save_done |->
      (result.body_last && (result.byte_class == CLS_BODY)) ||
      (result.request_ready && result.request_kind && (result.file_size == 32'd0)))
    else $error("save_done without body end or empty SAVE");

  // A byte accepted in body mode always comes out as a body byte
  a_body_class: assert property (@(posedge clk) disable iff (rst)
    accept && (parse_mode == MODE_BODY) |=> result.valid && (result.byte_class == CLS_BODY))
    else $error("body byte lost its class");

endmodule

// ===== sv/rsp_hdr_unit.sv =====
// Header line unit: key match for "filesize:", whitespace skip and saturating decimal accumulate.
// Depends on rsp_pkg. Purely combinational; state is held by the top level.
module rsp_hdr_unit #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  rsp_pkg::hdr_ctl_t      cur,
  input  logic [SIZE_BITS-1:0]   size,
  input  logic [7:0]             data,
  input  logic                   do_cr,
  input  logic                   do_byte,
  output rsp_pkg::hdr_ctl_t      upd,
  output logic [SIZE_BITS-1:0]   size_upd
);
  import rsp_pkg::*;

  hdr_ctl_t             mid;
  logic [7:0]           lc;
  logic [SIZE_BITS+3:0] acc;
  logic [SIZE_BITS-1:0] acc_sat;

  // size*10 + digit; anything above the top bits means saturation
  always_comb begin
    acc = ({4'b0, size} << 3) + ({4'b0, size} << 1) + (SIZE_BITS+4)'(data[3:0]);
    if (acc[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
      acc_sat = '1;
    end else begin
      acc_sat = acc[SIZE_BITS-1:0];
    end
  end

  assign lc = ((data >= 8'h41) && (data <= 8'h5a)) ? (data | 8'h20) : data;

  always_comb begin
    // held CR that did not end the line
    mid = cur;
    if (do_cr) begin
      if (cur.pos != 4'd15) begin
        mid.pos = cur.pos + 4'd1;
      end
      if ((cur.phase == PH_PREFIX) || (cur.phase == PH_DIGITS)) begin
        mid.phase = PH_IGNORE;
      end
    end

    upd      = mid;
    size_upd = size;
    if (do_byte) begin
      if (mid.pos != 4'd15) begin
        upd.pos = mid.pos + 4'd1;
      end
      case (mid.phase)
        PH_PREFIX: begin
          if ((mid.pos < 4'(KEY_LEN)) && (lc == key_char(mid.pos))) begin
            if (mid.pos == 4'(KEY_LEN - 1)) begin
              upd.phase = PH_SPACE;
              size_upd  = '0;
            end
          end else begin
            upd.phase = PH_IGNORE;
          end
        end
        PH_SPACE: begin
          if (!is_ws(data)) begin
            if (is_digit(data)) begin
              upd.phase = PH_DIGITS;
              size_upd  = acc_sat;
            end else begin
              upd.phase = PH_IGNORE;
            end
          end
        end
        PH_DIGITS: begin
          if (is_digit(data)) begin
            size_upd = acc_sat;
          end else begin
            upd.phase = PH_IGNORE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
